@@ sv/rf2d_pkg.sv @@
// Shared constants, register codes and control type for the 2D FFT unit.
`default_nettype none
package rf2d_pkg;

  localparam int MAX_LOG_SIZE = 6;
  localparam int SAMPLE_BITS  = 32;
  localparam int TWIDDLE_BITS = 18;

  localparam int LOG_BITS     = 3;
  localparam int RESULT_BITS  = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LOG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION  = 2'd2;

  // command from the controller to the transform engine
  typedef struct packed {
    logic                start;
    logic                busy;
    logic                direction;
    logic [LOG_BITS-1:0] lw;
    logic [LOG_BITS-1:0] lh;
  } eng_cmd_t;

endpackage
`default_nettype wire

@@ sv/rf2d_in_if.sv @@
// Input channel: load or read request beats.
`default_nettype none
interface rf2d_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] sample_real;
  logic [31:0] sample_imag;

  modport source (output valid, mode, sample_real, sample_imag, input ready);
  modport sink   (input valid, mode, sample_real, sample_imag, output ready);
endinterface
`default_nettype wire

@@ sv/rf2d_out_if.sv @@
// Result channel: transformed elements in row-major order.
`default_nettype none
interface rf2d_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_real;
  logic [31:0] result_imag;
  logic        last;

  modport source (output valid, result_real, result_imag, last, input ready);
  modport sink   (input valid, result_real, result_imag, last, output ready);
endinterface
`default_nettype wire

@@ sv/rf2d_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module rf2d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/rf2d_engine.sv @@
// Row-column FFT sequencer: line buffer RAM, shared butterfly, twiddle ROM.
`default_nettype none
module rf2d_engine #(
  parameter int MAX_LOG_SIZE = rf2d_pkg::MAX_LOG_SIZE,
  parameter int SAMPLE_BITS  = rf2d_pkg::SAMPLE_BITS,
  parameter int TWIDDLE_BITS = rf2d_pkg::TWIDDLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rf2d_pkg::eng_cmd_t            cmd,
  output logic                               done,
  output logic [2*MAX_LOG_SIZE-1:0]          st_raddr,
  input  wire logic [2*SAMPLE_BITS-1:0]      st_rdata,
  output logic                               st_we,
  output logic [2*MAX_LOG_SIZE-1:0]          st_waddr,
  output logic [2*SAMPLE_BITS-1:0]           st_wdata
);

  localparam int LA    = MAX_LOG_SIZE;
  localparam int AW    = 2 * MAX_LOG_SIZE;
  localparam int NL    = 1 << MAX_LOG_SIZE;
  localparam int HALF  = (NL + 1) / 2;
  localparam int KW    = (MAX_LOG_SIZE > 1) ? MAX_LOG_SIZE - 1 : 1;
  localparam int EW    = LA + 1;
  localparam int SW    = $clog2(MAX_LOG_SIZE + 1);
  localparam int SB    = SAMPLE_BITS;
  localparam int TW    = TWIDDLE_BITS;
  localparam int TF    = TWIDDLE_BITS - 2;
  localparam int LB    = SAMPLE_BITS + 2 * MAX_LOG_SIZE + 2;
  localparam int H     = (LB + 1) / 2;
  localparam int MW    = H + 1;
  localparam int PW    = MW + TW;
  localparam int AC    = LB + TW + 3;
  localparam int ROM_W = 2 * TW * HALF;
  localparam int LBW   = rf2d_pkg::LOG_BITS;

  localparam logic signed [LB:0] SAT_HI = (LB+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [LB:0] SAT_LO = (LB+1)'(-(64'sd1 <<< (SB - 1)));
  localparam longint Q_ONE = 64'sd1 <<< 30;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CPIN = 4'd1;
  localparam logic [3:0] S_BRDA = 4'd2;
  localparam logic [3:0] S_BRDB = 4'd3;
  localparam logic [3:0] S_BCAP = 4'd4;
  localparam logic [3:0] S_BMUL = 4'd5;
  localparam logic [3:0] S_BRND = 4'd6;
  localparam logic [3:0] S_BWRA = 4'd7;
  localparam logic [3:0] S_BWRB = 4'd8;
  localparam logic [3:0] S_CPOUT = 4'd9;

  function automatic longint unsigned isqrt(input longint unsigned xin);
    longint unsigned x, r, b;
    x = xin;
    r = 0;
    b = 64'd1 << 62;
    for (int t = 0; t < 32; t++) begin
      if (b > x) b = b >> 2;
    end
    for (int t = 0; t < 32; t++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic longint rshift(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint rom_value(input longint q30);
    longint v, one;
    v = rshift(q30, 30 - TF);
    one = 64'sd1 <<< TF;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v;
  endfunction

  // cos/sin table of 2*pi*k/2^MAX built by half-angle steps and rotations in Q30
  function automatic logic [ROM_W-1:0] build_rom();
    longint hc [MAX_LOG_SIZE+2];
    longint hs [MAX_LOG_SIZE+2];
    longint c, sn, nc, ns;
    int idx;
    logic [ROM_W-1:0] rom;
    rom = '0;
    for (int s = 0; s < MAX_LOG_SIZE + 2; s++) begin
      hc[s] = 0;
      hs[s] = 0;
    end
    hc[1] = -Q_ONE;
    hs[1] = 0;
    for (int s = 2; s <= MAX_LOG_SIZE; s++) begin
      hc[s] = longint'(isqrt(longint'(Q_ONE + hc[s-1]) << 29));
      hs[s] = longint'(isqrt(longint'(Q_ONE - hc[s-1]) << 29));
    end
    for (int k = 0; k < HALF; k++) begin
      c = Q_ONE;
      sn = 0;
      for (int b = 0; b + 2 <= MAX_LOG_SIZE; b++) begin
        if (((k >> b) & 1) != 0) begin
          idx = MAX_LOG_SIZE - b;
          nc = rshift(c * hc[idx] - sn * hs[idx], 30);
          ns = rshift(c * hs[idx] + sn * hc[idx], 30);
          c = nc;
          sn = ns;
        end
      end
      rom[(2*k)*TW +: TW]   = TW'(rom_value(c));
      rom[(2*k+1)*TW +: TW] = TW'(rom_value(sn));
    end
    return rom;
  endfunction

  localparam logic [ROM_W-1:0] TWID = build_rom();

  function automatic logic [LA-1:0] bitrev(input logic [LA-1:0] v, input logic [LBW-1:0] lg);
    logic [LA-1:0] r;
    for (int q = 0; q < LA; q++) begin
      r[q] = v[LA-1-q];
    end
    return r >> (LA - int'(lg));
  endfunction

  logic [3:0]             st_r;
  logic                   pass_r;
  logic [LA-1:0]          line_r;
  logic [EW-1:0]          e_r;
  logic                   cpv_r;
  logic [LA-1:0]          cpe_r;
  logic [SW-1:0]          s_r;
  logic [LA-1:0]          b_r;
  logic [3:0]             m_r;
  logic                   pv_r;
  logic [2:0]             ptag_r;
  logic                   done_r;
  logic [LBW-1:0]         lw_r, lh_r;
  logic                   dir_r;

  logic [2*LB-1:0]        a_r, x_r;
  logic signed [TW-1:0]   ur_r, ui_r, nui_r;
  logic signed [PW-1:0]   p_r;
  logic signed [AC-1:0]   accr_r, acci_r;
  logic signed [LB-1:0]   tr_r, ti_r;

  logic [LBW-1:0]         lg, lines_lg;
  logic [LA:0]            n_full, l_full;
  logic [LA-1:0]          n_mask, line_mask;
  logic [LA-1:0]          half, jj, ii, ii1, kk;
  logic [KW-1:0]          kidx;
  logic                   bfly_last, stage_last;
  logic [AW-1:0]          st_addr_e, st_addr_c;
  logic [LA-1:0]          ln_raddr, ln_waddr;
  logic                   ln_we;
  logic [2*LB-1:0]        ln_wdata, ln_rdata;
  logic signed [TW-1:0]   rom_cos, rom_sin;
  logic [LB-1:0]          xv;
  logic signed [LB-H-1:0] xh;
  logic signed [MW-1:0]   opnd;
  logic signed [TW-1:0]   twv;
  logic signed [AC-1:0]   addend;
  logic signed [LB-1:0]   a_re, a_im;
  logic [2*SB-1:0]        out_word;

  assign lg        = pass_r ? lh_r : lw_r;
  assign lines_lg  = pass_r ? lw_r : lh_r;
  assign n_full    = (LA+1)'(1) << lg;
  assign l_full    = (LA+1)'(1) << lines_lg;
  assign n_mask    = LA'(n_full - 1'b1);
  assign line_mask = LA'(l_full - 1'b1);
  assign bfly_last = (b_r == (n_mask >> 1));
  assign stage_last = (int'(s_r) == int'(lg));

  assign half = LA'(1) << (s_r - 1'b1);
  assign jj   = b_r & (half - 1'b1);
  assign ii   = ((b_r >> (s_r - 1'b1)) << s_r) | jj;
  assign ii1  = ii | half;
  assign kk   = jj << (SW'(MAX_LOG_SIZE) - s_r);
  assign kidx = kk[KW-1:0];
  assign rom_cos = TWID[(2*int'(kidx))*TW +: TW];
  assign rom_sin = TWID[(2*int'(kidx)+1)*TW +: TW];

  // row pass walks a row, column pass walks a column
  assign st_addr_e = pass_r ? ((AW'(cpe_r) << lw_r) | AW'(line_r))
                            : ((AW'(line_r) << lw_r) | AW'(cpe_r));
  assign st_addr_c = pass_r ? ((AW'(e_r[LA-1:0]) << lw_r) | AW'(line_r))
                            : ((AW'(line_r) << lw_r) | AW'(e_r[LA-1:0]));

  assign a_re = a_r[2*LB-1:LB];
  assign a_im = a_r[LB-1:0];

  always_comb begin
    ln_raddr = e_r[LA-1:0];
    ln_we    = 1'b0;
    ln_waddr = bitrev(cpe_r, lg);
    ln_wdata = {LB'($signed(st_rdata[2*SB-1:SB])), LB'($signed(st_rdata[SB-1:0]))};
    case (st_r)
      S_BRDA:  ln_raddr = ii;
      S_BRDB:  ln_raddr = ii1;
      S_CPIN:  ln_we = cpv_r;
      S_BWRA: begin
        ln_we    = 1'b1;
        ln_waddr = ii;
        ln_wdata = {a_re + tr_r, a_im + ti_r};
      end
      S_BWRB: begin
        ln_we    = 1'b1;
        ln_waddr = ii1;
        ln_wdata = {a_re - tr_r, a_im - ti_r};
      end
      default: ;
    endcase
  end

  rf2d_ram #(.WIDTH(2 * LB), .DEPTH(NL)) u_line (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (ln_wdata),
    .raddr (ln_raddr),
    .rdata (ln_rdata)
  );

  // multiplier operand: term = tag[2:1] (re*ur, im*-ui, im*ur, re*ui), tag[0] = high half
  always_comb begin
    case (m_r[2:1])
      2'd0:    begin xv = x_r[2*LB-1:LB]; twv = ur_r;  end
      2'd1:    begin xv = x_r[LB-1:0];    twv = nui_r; end
      2'd2:    begin xv = x_r[LB-1:0];    twv = ur_r;  end
      default: begin xv = x_r[2*LB-1:LB]; twv = ui_r;  end
    endcase
    xh   = xv[LB-1:H];
    opnd = m_r[0] ? MW'(xh) : $signed({1'b0, xv[H-1:0]});
    addend = ptag_r[0] ? (AC'(p_r) <<< H) : AC'(p_r);
  end

  // end of pass: forward scaling by 1/N, then saturation
  function automatic logic [SB-1:0] finish(input logic [LB-1:0] v, input logic [LBW-1:0] sh,
                                           input logic dir);
    logic signed [LB:0] w;
    w = (LB+1)'($signed(v));
    if (!dir) begin
      w = (w + ((LB+1)'(1) <<< (sh - 1'b1))) >>> sh;
    end
    if (w > SAT_HI) w = SAT_HI;
    if (w < SAT_LO) w = SAT_LO;
    return SB'(w);
  endfunction

  assign out_word = {finish(ln_rdata[2*LB-1:LB], lg, dir_r), finish(ln_rdata[LB-1:0], lg, dir_r)};

  assign st_raddr = st_addr_c;
  assign st_we    = (st_r == S_CPOUT) && cpv_r;
  assign st_waddr = st_addr_e;
  assign st_wdata = out_word;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cpv_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      pass_r <= 1'b0;
      line_r <= '0;
      e_r    <= '0;
      s_r    <= '0;
      b_r    <= '0;
      m_r    <= '0;
    end else begin
      done_r <= 1'b0;
      cpv_r  <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd.start) begin
            pass_r <= 1'b0;
            line_r <= '0;
            e_r    <= '0;
            st_r   <= S_CPIN;
          end
        end
        S_CPIN: begin
          cpv_r <= (e_r < EW'(n_full));
          if (e_r == EW'(n_full)) begin
            s_r  <= SW'(1);
            b_r  <= '0;
            st_r <= S_BRDA;
          end else begin
            e_r <= e_r + 1'b1;
          end
        end
        S_BRDA: st_r <= S_BRDB;
        S_BRDB: st_r <= S_BCAP;
        S_BCAP: begin
          m_r  <= '0;
          pv_r <= 1'b0;
          st_r <= S_BMUL;
        end
        S_BMUL: begin
          pv_r <= (m_r < 4'd8);
          if (m_r == 4'd8) begin
            st_r <= S_BRND;
          end else begin
            m_r <= m_r + 1'b1;
          end
        end
        S_BRND: st_r <= S_BWRA;
        S_BWRA: st_r <= S_BWRB;
        S_BWRB: begin
          // each butterfly retires its writes before the next one reads
          if (bfly_last) begin
            b_r <= '0;
            if (stage_last) begin
              e_r  <= '0;
              st_r <= S_CPOUT;
            end else begin
              s_r  <= s_r + 1'b1;
              st_r <= S_BRDA;
            end
          end else begin
            b_r  <= b_r + 1'b1;
            st_r <= S_BRDA;
          end
        end
        S_CPOUT: begin
          cpv_r <= (e_r < EW'(n_full));
          if (e_r == EW'(n_full)) begin
            e_r <= '0;
            if (line_r == line_mask) begin
              line_r <= '0;
              if (pass_r) begin
                done_r <= 1'b1;
                st_r   <= S_IDLE;
              end else begin
                pass_r <= 1'b1;
                st_r   <= S_CPIN;
              end
            end else begin
              line_r <= line_r + 1'b1;
              st_r   <= S_CPIN;
            end
          end else begin
            e_r <= e_r + 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cpe_r <= e_r[LA-1:0];
    if (st_r == S_IDLE && cmd.start) begin
      lw_r  <= cmd.lw;
      lh_r  <= cmd.lh;
      dir_r <= cmd.direction;
    end
    if (st_r == S_BRDA) begin
      ur_r  <= rom_cos;
      ui_r  <= dir_r ? rom_sin : -rom_sin;
      nui_r <= dir_r ? -rom_sin : rom_sin;
    end
    if (st_r == S_BRDB) a_r <= ln_rdata;
    if (st_r == S_BCAP) begin
      x_r    <= ln_rdata;
      accr_r <= '0;
      acci_r <= '0;
    end
    if (st_r == S_BMUL) begin
      p_r    <= opnd * twv;
      ptag_r <= m_r[2:0];
      if (pv_r) begin
        if (ptag_r[2]) acci_r <= acci_r + addend;
        else           accr_r <= accr_r + addend;
      end
    end
    if (st_r == S_BRND) begin
      tr_r <= LB'((accr_r + (AC'(1) <<< (TF - 1))) >>> TF);
      ti_r <= LB'((acci_r + (AC'(1) <<< (TF - 1))) >>> TF);
    end
  end

`ifndef SYNTHESIS
  a_wr_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> $past(st_r) == S_CPOUT)
    else $error("store write outside copy-out");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> st_r == S_IDLE && pass_r)
    else $error("done without finishing column pass");
  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_BRND |-> $past(m_r) == 4'd8)
    else $error("butterfly rounded before all partial products");
`endif

endmodule
`default_nettype wire

@@ sv/rf2d_ctrl.sv @@
// Load/read sequencing, configuration registers and result register.
`default_nettype none
module rf2d_ctrl #(
  parameter int MAX_LOG_SIZE = rf2d_pkg::MAX_LOG_SIZE,
  parameter int SAMPLE_BITS  = rf2d_pkg::SAMPLE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  rf2d_in_if.sink                                  in_ch,
  rf2d_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [rf2d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [rf2d_pkg::CFG_BITS-1:0]       cfg_data,
  output rf2d_pkg::eng_cmd_t                       cmd,
  input  wire logic                                eng_done,
  output logic                                     st_we,
  output logic [2*MAX_LOG_SIZE-1:0]                st_waddr,
  output logic [2*SAMPLE_BITS-1:0]                 st_wdata,
  output logic [2*MAX_LOG_SIZE-1:0]                st_raddr,
  input  wire logic [2*SAMPLE_BITS-1:0]            st_rdata
);

  localparam int AW  = 2 * MAX_LOG_SIZE;
  localparam int CW  = 2 * MAX_LOG_SIZE + 1;
  localparam int SB  = SAMPLE_BITS;
  localparam int LBW = rf2d_pkg::LOG_BITS;
  localparam int RB  = rf2d_pkg::RESULT_BITS;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (SB - 1));

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_BUSY = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;

  function automatic logic [LBW-1:0] clamp_log(input logic [LBW-1:0] v);
    if (v == '0) return LBW'(1);
    if (int'(v) > MAX_LOG_SIZE) return LBW'(MAX_LOG_SIZE);
    return v;
  endfunction

  function automatic logic [SB-1:0] sat_in(input logic [31:0] v);
    logic signed [63:0] w;
    w = 64'($signed(v));
    if (w > SAT_HI) w = SAT_HI;
    if (w < SAT_LO) w = SAT_LO;
    return SB'(w);
  endfunction

  logic [1:0]      phase_r;
  logic [CW-1:0]   load_idx_r, read_idx_r;
  logic [LBW-1:0]  lw_r, lh_r, run_lw_r, run_lh_r;
  logic            dir_r;
  logic            start_r;
  logic            rd_pend_r, last_pend_r;
  logic            out_valid_r, out_last_r;
  logic [RB-1:0]   out_re_r, out_im_r;

  logic            fire, is_load, is_read;
  logic [CW-1:0]   total_load, total_run, load_inc, read_inc;
  logic            read_last;
  logic signed [SB-1:0] rd_re, rd_im;

  assign in_ch.ready = (phase_r != PH_BUSY) && !rd_pend_r && (!out_valid_r || out_ch.ready);
  assign fire    = in_ch.valid && in_ch.ready;
  assign is_load = fire && !in_ch.mode && (phase_r == PH_LOAD);
  assign is_read = fire && in_ch.mode && (phase_r == PH_READ);

  assign total_load = CW'(1) << ({1'b0, lw_r} + {1'b0, lh_r});
  assign total_run  = CW'(1) << ({1'b0, run_lw_r} + {1'b0, run_lh_r});
  assign load_inc   = load_idx_r + 1'b1;
  assign read_inc   = read_idx_r + 1'b1;
  assign read_last  = (read_inc >= total_run);

  assign st_we    = is_load && (load_idx_r < total_load);
  assign st_waddr = load_idx_r[AW-1:0];
  assign st_wdata = {sat_in(in_ch.sample_real), sat_in(in_ch.sample_imag)};
  assign st_raddr = read_idx_r[AW-1:0];

  assign cmd.start     = start_r;
  assign cmd.busy      = (phase_r == PH_BUSY);
  assign cmd.direction = dir_r;
  assign cmd.lw        = run_lw_r;
  assign cmd.lh        = run_lh_r;

  assign rd_re = st_rdata[2*SB-1:SB];
  assign rd_im = st_rdata[SB-1:0];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_real = out_re_r;
  assign out_ch.result_imag = out_im_r;
  assign out_ch.last        = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOAD;
      load_idx_r  <= '0;
      read_idx_r  <= '0;
      lw_r        <= clamp_log(LBW'(6));
      lh_r        <= clamp_log(LBW'(6));
      dir_r       <= 1'b0;
      run_lw_r    <= LBW'(1);
      run_lh_r    <= LBW'(1);
      start_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r   <= 1'b0;
      rd_pend_r <= is_read;
      if (cfg_we) begin
        case (cfg_index)
          rf2d_pkg::REG_LOG_WIDTH:  lw_r  <= clamp_log(cfg_data);
          rf2d_pkg::REG_LOG_HEIGHT: lh_r  <= clamp_log(cfg_data);
          rf2d_pkg::REG_DIRECTION:  dir_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (is_load) begin
        load_idx_r <= load_inc;
        // the last beat, or one past the count (dropped), starts the transform
        if (load_inc >= total_load) begin
          run_lw_r <= lw_r;
          run_lh_r <= lh_r;
          start_r  <= 1'b1;
          phase_r  <= PH_BUSY;
        end
      end
      if (eng_done) begin
        phase_r    <= PH_READ;
        read_idx_r <= '0;
      end
      if (is_read) begin
        if (read_last) begin
          phase_r    <= PH_LOAD;
          load_idx_r <= '0;
          read_idx_r <= '0;
        end else begin
          read_idx_r <= read_inc;
        end
      end
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) last_pend_r <= read_last;
    if (rd_pend_r) begin
      out_re_r   <= RB'(rd_re);
      out_im_r   <= RB'(rd_im);
      out_last_r <= last_pend_r;
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> phase_r == PH_BUSY)
    else $error("transform started outside busy phase");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> phase_r == PH_BUSY)
    else $error("engine done while not busy");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> phase_r != PH_BUSY)
    else $error("input ready during transform");
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("store read did not reach result register");
`endif

endmodule
`default_nettype wire

@@ sv/radix2_fft_2d_unit.sv @@
// Top level of the row-column radix-2 2D FFT unit.
//
//  channel   dir  signals                                       meaning
//  in_ch     in   valid ready mode sample_real sample_imag      load (mode 0) / read (mode 1)
//  out_ch    out  valid ready result_real result_imag last      one element per read beat
//  cfg_*     in   cfg_we cfg_index cfg_data                     log_width, log_height, direction
//
//  A load beat writes the store; a read beat goes through the store read, then the
//  result register, and no input is taken while its read is pending. Transform of
//  W x H: each line is copied in, run through one shared butterfly with a single 24x18
//  multiplier (8 partial products) and copied back. No input is taken during a transform.
//  Reset is synchronous; the sample store has no clearing pass.
//  A stalled result holds back the next input beat, load or read.
`default_nettype none
module radix2_fft_2d_unit #(
  parameter int MAX_LOG_SIZE = rf2d_pkg::MAX_LOG_SIZE,
  parameter int SAMPLE_BITS  = rf2d_pkg::SAMPLE_BITS,
  parameter int TWIDDLE_BITS = rf2d_pkg::TWIDDLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rf2d_in_if.sink                                in_ch,
  rf2d_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rf2d_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [rf2d_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int AW = 2 * MAX_LOG_SIZE;
  localparam int DW = 2 * SAMPLE_BITS;

  rf2d_pkg::eng_cmd_t cmd;
  logic               eng_done;
  logic               c_we, e_we, s_we;
  logic [AW-1:0]      c_waddr, e_waddr, s_waddr, c_raddr, e_raddr, s_raddr;
  logic [DW-1:0]      c_wdata, e_wdata, s_wdata, s_rdata;

  rf2d_ctrl #(.MAX_LOG_SIZE(MAX_LOG_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .eng_done  (eng_done),
    .st_we     (c_we),
    .st_waddr  (c_waddr),
    .st_wdata  (c_wdata),
    .st_raddr  (c_raddr),
    .st_rdata  (s_rdata)
  );

  rf2d_engine #(
    .MAX_LOG_SIZE (MAX_LOG_SIZE),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .done     (eng_done),
    .st_raddr (e_raddr),
    .st_rdata (s_rdata),
    .st_we    (e_we),
    .st_waddr (e_waddr),
    .st_wdata (e_wdata)
  );

  // the engine owns the store while the transform runs
  assign s_we    = cmd.busy ? e_we    : c_we;
  assign s_waddr = cmd.busy ? e_waddr : c_waddr;
  assign s_wdata = cmd.busy ? e_wdata : c_wdata;
  assign s_raddr = cmd.busy ? e_raddr : c_raddr;

  rf2d_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule
`default_nettype wire
